### rtl/hrht_pkg.sv
`timescale 1ns / 1ps

package hrht_pkg;

   // Request transaction payload
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_payload_type;

   // Field tags
   typedef enum logic [3:0] {
      TAG_NONE       = 4'd0,
      TAG_METHOD     = 4'd1,
      TAG_URL        = 4'd2,
      TAG_VERSION    = 4'd3,
      TAG_CONNECTION = 4'd4,
      TAG_ACCEPT     = 4'd5,
      TAG_LENGTH     = 4'd6,
      TAG_TYPE       = 4'd7,
      TAG_ENCODING   = 4'd8
   } tag_type;

   // Status codes
   typedef enum logic [1:0] {
      ST_PARSING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_ERROR    = 2'd2,
      ST_ENDED    = 2'd3
   } status_type;

   // Result transaction payload
   typedef struct packed {
      logic [7:0] byte_out;
      tag_type    field_tag;
      logic       line_end;
      status_type status;
   } rsp_payload_type;

   // Parser phases
   typedef enum logic [2:0] {
      PH_METHOD   = 3'd0,
      PH_URL      = 3'd1,
      PH_VERSION  = 3'd2,
      PH_HEADER   = 3'd3,
      PH_COMPLETE = 3'd4,
      PH_ERROR    = 3'd5,
      PH_ENDED    = 3'd6
   } phase_type;

   localparam int NUM_PREFIXES = 5;
   localparam int PREFIX_MAX   = 19;
   localparam logic [4:0] POS_MAX = 5'd31;
   localparam logic [4:0] FIRST_LINE_MIN = 5'd4;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   // Header prefixes, right-aligned with zero padding above; first character in the highest used byte
   localparam logic [PREFIX_MAX*8-1:0] PFX_CONN  = "Connection: ";
   localparam logic [PREFIX_MAX*8-1:0] PFX_ACC   = "Accept: ";
   localparam logic [PREFIX_MAX*8-1:0] PFX_CLEN  = "Content-Length: ";
   localparam logic [PREFIX_MAX*8-1:0] PFX_CTYPE = "Content-Type: ";
   localparam logic [PREFIX_MAX*8-1:0] PFX_ENC   = "Transfer-Encoding: ";

   function automatic logic [4:0] prefix_len(input logic [2:0] idx);
      logic [4:0] len;
      begin
         case (idx)
            3'd0:    len = 5'd12;
            3'd1:    len = 5'd8;
            3'd2:    len = 5'd16;
            3'd3:    len = 5'd14;
            default: len = 5'd19;
         endcase
         return len;
      end
   endfunction

   function automatic logic [PREFIX_MAX*8-1:0] prefix_text(input logic [2:0] idx);
      logic [PREFIX_MAX*8-1:0] txt;
      begin
         case (idx)
            3'd0:    txt = PFX_CONN;
            3'd1:    txt = PFX_ACC;
            3'd2:    txt = PFX_CLEN;
            3'd3:    txt = PFX_CTYPE;
            default: txt = PFX_ENC;
         endcase
         return txt;
      end
   endfunction

   // Character at line position pos of prefix idx; pos must be below its length
   function automatic logic [7:0] prefix_char(input logic [2:0] idx, input logic [4:0] pos);
      logic [PREFIX_MAX*8-1:0] txt;
      logic [7:0]              bit_index;
      begin
         txt       = prefix_text(idx);
         bit_index = {prefix_len(idx) - 5'd1 - pos, 3'b000};
         return txt[bit_index +: 8];
      end
   endfunction

   function automatic status_type status_of(input phase_type ph);
      status_type st;
      begin
         case (ph)
            PH_COMPLETE: st = ST_COMPLETE;
            PH_ERROR:    st = ST_ERROR;
            PH_ENDED:    st = ST_ENDED;
            default:     st = ST_PARSING;
         endcase
         return st;
      end
   endfunction

endpackage

### rtl/http_request_head_tokenizer_unit.sv
`timescale 1ns / 1ps

// A request byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle while results are taken; while a result waits the input register takes one byte.
// The whole tokenizer step is one pass of compare logic between the two registers.
// Reset (synchronous, active high) empties both registers and returns the parser to the
// method phase at line position zero with all header prefixes as candidates.
module http_request_head_tokenizer_unit
   import hrht_pkg::*;
#(
   parameter int METHOD_LIMIT = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam logic [4:0] METHOD_MAX = 5'(METHOD_LIMIT);

   // Pipeline registers
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;

   // Parser state
   phase_type   phase_ff,      phase_in;
   logic [4:0]  line_pos_ff,   line_pos_in;
   logic [NUM_PREFIXES-1:0] cand_ff, cand_in;
   tag_type     value_ff,      value_in;
   logic        cr_seen_ff,    cr_seen_in;
   logic [1:0]  spaces_ff,     spaces_in;

   logic            move;
   rsp_payload_type result;

   // Advance when the result register is free or being emptied
   assign move      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // Tokenizer step for the byte in the input register
   always_comb begin
      logic [7:0] b;
      logic       is_cr;
      logic       is_lf;
      logic       ends;
      logic [4:0] pos_next;
      tag_type    tag;

      b        = in_data_ff.byte_in;
      is_cr    = (b == CHAR_CR);
      is_lf    = (b == CHAR_LF);
      ends     = is_lf && cr_seen_ff;
      pos_next = (line_pos_ff < POS_MAX) ? line_pos_ff + 5'd1 : line_pos_ff;
      tag      = TAG_NONE;

      phase_in    = phase_ff;
      line_pos_in = line_pos_ff;
      cand_in     = cand_ff;
      value_in    = value_ff;
      cr_seen_in  = cr_seen_ff;
      spaces_in   = spaces_ff;

      result.byte_out  = b;
      result.line_end  = 1'b0;

      if (phase_ff == PH_METHOD || phase_ff == PH_URL || phase_ff == PH_VERSION) begin
         result.line_end = ends;
         if (phase_ff == PH_METHOD && line_pos_ff >= METHOD_MAX) begin
            phase_in = PH_ERROR;
         end else if (ends) begin
            if (line_pos_ff <= FIRST_LINE_MIN || spaces_ff < 2'd2) begin
               phase_in = PH_ERROR;
            end else begin
               phase_in    = PH_HEADER;
               line_pos_in = '0;
               cand_in     = '1;
               value_in    = TAG_NONE;
            end
         end else begin
            if (b == CHAR_SPACE && spaces_ff < 2'd2) begin
               spaces_in = spaces_ff + 2'd1;
               phase_in  = (phase_ff == PH_METHOD) ? PH_URL : PH_VERSION;
            end else if (!is_cr && !is_lf) begin
               case (phase_ff)
                  PH_METHOD: tag = TAG_METHOD;
                  PH_URL:    tag = TAG_URL;
                  default:   tag = TAG_VERSION;
               endcase
            end
            line_pos_in = pos_next;
         end
         cr_seen_in = is_cr;
      end else if (phase_ff == PH_HEADER) begin
         result.line_end = ends;
         if (ends) begin
            if (line_pos_ff == 5'd1) begin
               phase_in = PH_COMPLETE;
            end
            line_pos_in = '0;
            cand_in     = '1;
            value_in    = TAG_NONE;
         end else begin
            if (value_ff != TAG_NONE) begin
               if (!is_cr && !is_lf) begin
                  tag = value_ff;
               end
            end else begin
               // Match the byte against each prefix still in play
               for (int i = 0; i < NUM_PREFIXES; i++) begin
                  if (cand_ff[i] && line_pos_ff < prefix_len(3'(i))) begin
                     if (b != prefix_char(3'(i), line_pos_ff)) begin
                        cand_in[i] = 1'b0;
                     end else if (line_pos_ff == prefix_len(3'(i)) - 5'd1) begin
                        value_in = tag_type'(4'(TAG_CONNECTION) + 4'(i));
                     end
                  end
               end
            end
            line_pos_in = pos_next;
         end
         cr_seen_in = is_cr;
      end

      // Close out a buffer that ends before the blank line
      if (phase_ff != PH_COMPLETE && phase_ff != PH_ERROR && phase_ff != PH_ENDED &&
          in_data_ff.last_byte &&
          phase_in != PH_COMPLETE && phase_in != PH_ERROR && phase_in != PH_ENDED) begin
         phase_in = (phase_in == PH_HEADER) ? PH_ENDED : PH_ERROR;
      end

      result.field_tag = tag;
      result.status    = status_of(phase_in);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_METHOD;
         line_pos_ff  <= '0;
         cand_ff      <= '1;
         value_ff     <= TAG_NONE;
         cr_seen_ff   <= 1'b0;
         spaces_ff    <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (move) begin
            phase_ff    <= phase_in;
            line_pos_ff <= line_pos_in;
            cand_ff     <= cand_in;
            value_ff    <= value_in;
            cr_seen_ff  <= cr_seen_in;
            spaces_ff   <= spaces_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (move) begin
         out_data_ff <= result;
      end
   end

endmodule
